FILE: rtl/lsos_pkg.sv
// Package with the constants and types of the lidar sector obstacle steering core.
`default_nettype none
package lsos_pkg;

	localparam int unsigned MAX_SCAN_POINTS = 4096;
	localparam int unsigned SECTOR_COUNT    = 8;
	localparam int unsigned IDX_W           = $clog2(MAX_SCAN_POINTS);
	localparam int unsigned NPTS_W          = 13;
	localparam int unsigned DIST_W          = 16;
	localparam int unsigned CMD_W           = 2;
	localparam int unsigned CFG_IDX_W       = 2;
	localparam int unsigned SEC_W           = $clog2(SECTOR_COUNT);

	localparam logic [DIST_W-1:0] FAR_MM = '1;

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_SCAN_POINTS    = 2'd0,
		REG_FRONT_LIMIT_MM = 2'd1,
		REG_SIDE_LIMIT_MM  = 2'd2,
		REG_SIDES_CLOSE_MM = 2'd3
	} reg_idx_t;

	typedef enum logic {
		OP_SAMPLE = 1'b0,
		OP_TICK   = 1'b1
	} op_t;

	localparam logic [SEC_W-1:0] SEC_FRONT       = 3'd0;
	localparam logic [SEC_W-1:0] SEC_FRONT_LEFT  = 3'd1;
	localparam logic [SEC_W-1:0] SEC_LEFT        = 3'd2;
	localparam logic [SEC_W-1:0] SEC_RIGHT       = 3'd6;
	localparam logic [SEC_W-1:0] SEC_FRONT_RIGHT = 3'd7;

	localparam logic signed [CMD_W-1:0] CMD_POS  = 2'sb01;
	localparam logic signed [CMD_W-1:0] CMD_ZERO = 2'sb00;
	localparam logic signed [CMD_W-1:0] CMD_NEG  = 2'sb11;

	typedef logic [SECTOR_COUNT-1:0][DIST_W-1:0] sector_mins_t;

endpackage : lsos_pkg
`default_nettype wire

FILE: rtl/lidar_sector_obstacle_steering_core.sv
// Top level of the lidar sector obstacle steering core.
//
//  channel | direction | handshake                | payload
//  s_      | in        | s_tvalid / s_tready      | tdata: range_mm, range_finite;
//          |           |                          | tuser: operation; tlast: last_of_scan
//  m_      | out       | m_tvalid / m_tready      | tdata: forward_cmd, strafe_cmd, turn_cmd
//  cfg_    | in        | cfg_valid / cfg_ready    | cfg_index, cfg_data
//
// One word is accepted per cycle while s_tready is high. A word is registered in
// the input stage and handled from there; a tick word goes on from the input
// stage into the output register. Samples give no output word and never stall.
// A tick in the input stage waits only while the output register is full and
// not being taken, which then holds s_tready low. Reset sets all sector minima
// to far and the registers to their default values; no clearing pass is needed.
`default_nettype none
module lidar_sector_obstacle_steering_core
	import lsos_pkg::*;
(
	input  wire logic                 clk,
	input  wire logic                 arst_n,
	input  wire logic                 s_tvalid,
	output logic                      s_tready,
	input  wire logic [23:0]          s_tdata,   // [15:0] range_mm, [16] range_finite, zeros
	input  wire logic [0:0]           s_tuser,   // [0] operation
	input  wire logic                 s_tlast,
	output logic                      m_tvalid,
	input  wire logic                 m_tready,
	output logic [7:0]                m_tdata,   // [1:0] forward_cmd, [3:2] strafe_cmd,
	                                             // [5:4] turn_cmd, zeros
	input  wire logic                 cfg_valid,
	output logic                      cfg_ready,
	input  wire logic [CFG_IDX_W-1:0] cfg_index,
	input  wire logic [DIST_W-1:0]    cfg_data
);

	logic [NPTS_W-1:0] scan_points_q;
	logic [DIST_W-1:0] front_limit_q;
	logic [DIST_W-1:0] side_limit_q;
	logic [DIST_W-1:0] sides_close_q;

	logic              valid_s1;
	op_t               op_s1;
	logic [DIST_W-1:0] range_s1;
	logic              finite_s1;
	logic              last_s1;

	logic [IDX_W-1:0]  idx_q;
	sector_mins_t      running_q;
	sector_mins_t      held_q;
	sector_mins_t      running_nxt;

	logic              out_valid_q;
	logic [7:0]        out_data_q;

	logic              advance;
	logic              do_sample;
	logic              do_tick;
	logic              commit;

	logic [NPTS_W-1:0] n_clamp;
	logic [NPTS_W-4:0] sec_len;
	logic [NPTS_W-5:0] half_len;
	logic [NPTS_W-1:0] bound [SECTOR_COUNT];
	logic [NPTS_W-1:0] front_tail;
	logic [NPTS_W-1:0] k_ext;
	logic [DIST_W-1:0] sample_v;
	logic [SECTOR_COUNT-1:0] hit;

	logic              front_blk;
	logic              left_blk;
	logic              right_blk;
	logic              corridor;
	logic signed [CMD_W-1:0] fwd_cmd;
	logic signed [CMD_W-1:0] strafe_cmd;
	logic signed [CMD_W-1:0] turn_cmd;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			scan_points_q <= NPTS_W'(360);
			front_limit_q <= DIST_W'(350);
			side_limit_q  <= DIST_W'(220);
			sides_close_q <= DIST_W'(400);
		end else if (cfg_valid) begin
			case (reg_idx_t'(cfg_index))
				REG_SCAN_POINTS:    scan_points_q <= cfg_data[NPTS_W-1:0];
				REG_FRONT_LIMIT_MM: front_limit_q <= cfg_data;
				REG_SIDE_LIMIT_MM:  side_limit_q  <= cfg_data;
				REG_SIDES_CLOSE_MM: sides_close_q <= cfg_data;
				default: ;
			endcase
		end
	end

	assign advance   = !valid_s1 || (op_s1 == OP_SAMPLE) || !out_valid_q || m_tready;
	assign s_tready  = advance;
	assign do_sample = valid_s1 && (op_s1 == OP_SAMPLE);
	assign do_tick   = valid_s1 && (op_s1 == OP_TICK) && advance;
	assign commit    = do_sample && last_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (advance) begin
			valid_s1 <= s_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (advance && s_tvalid) begin
			op_s1     <= op_t'(s_tuser[0]);
			range_s1  <= s_tdata[DIST_W-1:0];
			finite_s1 <= s_tdata[DIST_W];
			last_s1   <= s_tlast;
		end
	end

	always_comb begin
		n_clamp = (scan_points_q > NPTS_W'(MAX_SCAN_POINTS)) ?
			NPTS_W'(MAX_SCAN_POINTS) : scan_points_q;
		sec_len  = n_clamp[NPTS_W-1:3];
		half_len = sec_len[NPTS_W-4:1];
		for (int i = 0; i < SECTOR_COUNT; i++) begin
			bound[i] = NPTS_W'(NPTS_W'(sec_len) * NPTS_W'(i));
		end
		front_tail = bound[SECTOR_COUNT-1] + NPTS_W'(half_len);
		k_ext      = NPTS_W'(idx_q);
		sample_v   = finite_s1 ? range_s1 : FAR_MM;

		hit    = '0;
		hit[0] = (k_ext < NPTS_W'(half_len)) || (k_ext >= front_tail);
		for (int i = 1; i < SECTOR_COUNT - 1; i++) begin
			hit[i] = (k_ext >= bound[i]) && (k_ext < bound[i+1]);
		end
		hit[SECTOR_COUNT-1] = k_ext >= bound[SECTOR_COUNT-1];
		if (k_ext >= n_clamp) begin
			hit = '0;
		end

		for (int i = 0; i < SECTOR_COUNT; i++) begin
			running_nxt[i] = (hit[i] && (sample_v < running_q[i])) ? sample_v : running_q[i];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			idx_q     <= '0;
			running_q <= {SECTOR_COUNT{FAR_MM}};
			held_q    <= {SECTOR_COUNT{FAR_MM}};
		end else if (do_sample) begin
			if (last_s1) begin
				idx_q     <= '0;
				held_q    <= running_nxt;
				running_q <= {SECTOR_COUNT{FAR_MM}};
			end else begin
				idx_q     <= idx_q + IDX_W'(1);
				running_q <= running_nxt;
			end
		end
	end

	always_comb begin
		front_blk  = held_q[SEC_FRONT] < front_limit_q;
		left_blk   = held_q[SEC_LEFT] < side_limit_q;
		right_blk  = held_q[SEC_RIGHT] < side_limit_q;
		corridor   = (held_q[SEC_LEFT] < sides_close_q) && (held_q[SEC_RIGHT] < sides_close_q);
		fwd_cmd    = CMD_ZERO;
		strafe_cmd = CMD_ZERO;
		turn_cmd   = CMD_ZERO;
		if (!front_blk && corridor) begin
			fwd_cmd = CMD_POS;
		end else if (!front_blk) begin
			if (!left_blk && right_blk) begin
				strafe_cmd = CMD_POS;
			end else if (left_blk && !right_blk) begin
				strafe_cmd = CMD_NEG;
			end else begin
				fwd_cmd = CMD_POS;
			end
		end else begin
			turn_cmd = (held_q[SEC_FRONT_LEFT] > held_q[SEC_FRONT_RIGHT]) ? CMD_POS : CMD_NEG;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (do_tick) begin
			out_valid_q <= 1'b1;
		end else if (m_tready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (do_tick) begin
			out_data_q <= {2'b00, turn_cmd, strafe_cmd, fwd_cmd};
		end
	end

	assign m_tvalid = out_valid_q;
	assign m_tdata  = out_data_q;

	a_ready_low_only_for_tick: assert property (@(posedge clk) disable iff (!arst_n)
		!s_tready |-> (valid_s1 && op_s1 == OP_TICK && out_valid_q))
		else $error("input stalled without a waiting tick");

	a_commit_resets_index: assert property (@(posedge clk) disable iff (!arst_n)
		commit |=> (idx_q == '0 && running_q == {SECTOR_COUNT{FAR_MM}}))
		else $error("commit did not restart the scan");

	a_held_only_on_commit: assert property (@(posedge clk) disable iff (!arst_n)
		!commit |=> $stable(held_q))
		else $error("held minima changed without a commit");

	a_one_motion: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid |-> ($countones({m_tdata[1:0] != 2'b00, m_tdata[3:2] != 2'b00,
			m_tdata[5:4] != 2'b00}) == 1))
		else $error("output word must carry exactly one motion");

endmodule : lidar_sector_obstacle_steering_core
`default_nettype wire
